[rtl/dsoa_pkg.sv]
// ----------------------------------------------------------------------------
// dsoa_pkg
// Shared types, codes and lookup functions for the SOA record field parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dsoa_pkg;

    localparam int unsigned MAX_RECORD_BYTES_DEF = 1024;
    localparam int unsigned OFFSET_W             = 10;
    localparam int unsigned VALUE_W              = 32;
    localparam int unsigned RQ_DEPTH             = 4;
    localparam int unsigned RQ_AW                = $clog2(RQ_DEPTH);

    // Parse phases, one-hot
    typedef enum logic [13:0] {
        PH_IDLE    = 14'b00000000000001,
        PH_OWNER   = 14'b00000000000010,
        PH_TYPE    = 14'b00000000000100,
        PH_CLASS   = 14'b00000000001000,
        PH_TTL     = 14'b00000000010000,
        PH_RDLEN   = 14'b00000000100000,
        PH_NS      = 14'b00000001000000,
        PH_MAIL    = 14'b00000010000000,
        PH_SERIAL  = 14'b00000100000000,
        PH_REFRESH = 14'b00001000000000,
        PH_RETRY   = 14'b00010000000000,
        PH_EXPIRE  = 14'b00100000000000,
        PH_MINIMUM = 14'b01000000000000,
        PH_DONE    = 14'b10000000000000
    } t_phase;

    typedef enum logic [3:0] {
        KIND_OWNER   = 4'd0,
        KIND_TYPE    = 4'd1,
        KIND_CLASS   = 4'd2,
        KIND_TTL     = 4'd3,
        KIND_NS      = 4'd4,
        KIND_MAIL    = 4'd5,
        KIND_SERIAL  = 4'd6,
        KIND_REFRESH = 4'd7,
        KIND_RETRY   = 4'd8,
        KIND_EXPIRE  = 4'd9,
        KIND_MINIMUM = 4'd10,
        KIND_TRUNC   = 4'd11
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [VALUE_W-1:0]    value;
        logic [OFFSET_W-1:0]   offset;
        logic                  via_ptr;
        logic                  last;
    } t_result;

    // Up to two results pushed per processed byte
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    function automatic t_kind phase_kind(input t_phase ph);
        t_kind k;
        unique case (ph)
            PH_TYPE:    k = KIND_TYPE;
            PH_CLASS:   k = KIND_CLASS;
            PH_TTL:     k = KIND_TTL;
            PH_NS:      k = KIND_NS;
            PH_MAIL:    k = KIND_MAIL;
            PH_SERIAL:  k = KIND_SERIAL;
            PH_REFRESH: k = KIND_REFRESH;
            PH_RETRY:   k = KIND_RETRY;
            PH_EXPIRE:  k = KIND_EXPIRE;
            PH_MINIMUM: k = KIND_MINIMUM;
            default:    k = KIND_OWNER;
        endcase
        return k;
    endfunction

    function automatic logic [2:0] phase_size(input t_phase ph);
        logic [2:0] s;
        unique case (ph) inside
            PH_TYPE, PH_CLASS, PH_RDLEN:                  s = 3'd2;
            PH_TTL, PH_SERIAL, PH_REFRESH, PH_RETRY,
            PH_EXPIRE, PH_MINIMUM:                        s = 3'd4;
            default:                                      s = 3'd0;
        endcase
        return s;
    endfunction

    function automatic t_phase phase_succ(input t_phase ph);
        t_phase p;
        unique case (ph)
            PH_OWNER:   p = PH_TYPE;
            PH_TYPE:    p = PH_CLASS;
            PH_CLASS:   p = PH_TTL;
            PH_TTL:     p = PH_RDLEN;
            PH_RDLEN:   p = PH_NS;
            PH_NS:      p = PH_MAIL;
            PH_MAIL:    p = PH_SERIAL;
            PH_SERIAL:  p = PH_REFRESH;
            PH_REFRESH: p = PH_RETRY;
            PH_RETRY:   p = PH_EXPIRE;
            PH_EXPIRE:  p = PH_MINIMUM;
            default:    p = PH_DONE;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

[rtl/dsoa_if.sv]
// ----------------------------------------------------------------------------
// dsoa_if
// Valid/ready channels for record bytes in and parsed fields out.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsoa_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       record_start;

    modport source (output valid, output data_byte, output record_start, input ready);
    modport sink   (input valid, input data_byte, input record_start, output ready);
endinterface

interface dsoa_out_if;
    logic                               valid;
    logic                               ready;
    logic [3:0]                         field_kind;
    logic [dsoa_pkg::VALUE_W-1:0]       field_value;
    logic [dsoa_pkg::OFFSET_W-1:0]      field_offset;
    logic                               name_via_pointer;
    logic                               result_last;

    modport source (output valid, output field_kind, output field_value,
                    output field_offset, output name_via_pointer,
                    output result_last, input ready);
    modport sink   (input valid, input field_kind, input field_value,
                    input field_offset, input name_via_pointer,
                    input result_last, output ready);
endinterface

`default_nettype wire

[rtl/dsoa_core.sv]
// ----------------------------------------------------------------------------
// dsoa_core
// Input register and per-byte parse step; yields up to two results a byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dsoa_core #(
    parameter int unsigned MAX_RECORD_BYTES = dsoa_pkg::MAX_RECORD_BYTES_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    dsoa_in_if.sink              i_rec,
    input  wire logic            i_room,
    output dsoa_pkg::t_push      o_push
);

    localparam int unsigned OFF_MAX = (1 << dsoa_pkg::OFFSET_W) - 1;
    localparam int unsigned CAP_INT = (MAX_RECORD_BYTES - 1 > OFF_MAX) ?
                                      OFF_MAX : MAX_RECORD_BYTES - 1;
    localparam logic [dsoa_pkg::OFFSET_W-1:0] OFFSET_CAP = dsoa_pkg::OFFSET_W'(CAP_INT);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;

    // parse state
    dsoa_pkg::t_phase              r_phase,  n_phase;
    logic [2:0]                    r_bleft,  n_bleft;
    logic [7:0]                    r_lbl,    n_lbl;
    logic [7:0]                    r_nlen,   n_nlen;
    logic [31:0]                   r_acc,    n_acc;
    logic [dsoa_pkg::OFFSET_W-1:0] r_roff,   n_roff;
    logic [dsoa_pkg::OFFSET_W-1:0] r_fstart, n_fstart;
    logic                          r_inptr,  n_inptr;

    logic                          w_fire;
    logic                          w_trunc;
    logic                          w_finish;
    logic                          w_emit;
    logic                          w_ptr;
    logic [31:0]                   w_value;
    dsoa_pkg::t_kind               w_kind;
    logic [dsoa_pkg::OFFSET_W-1:0] w_estart;
    logic [dsoa_pkg::OFFSET_W-1:0] w_nxt;
    dsoa_pkg::t_phase              w_next_ph;
    dsoa_pkg::t_result             w_trunc_res;
    dsoa_pkg::t_result             w_field_res;

    assign w_fire      = r_in_valid && i_room;
    assign i_rec.ready = i_rst_n && (!r_in_valid || w_fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rec.valid && i_rec.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rec.valid && i_rec.ready) begin
            r_in_byte  <= i_rec.data_byte;
            r_in_start <= i_rec.record_start;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_bleft   = r_bleft;
        n_lbl     = r_lbl;
        n_nlen    = r_nlen;
        n_acc     = r_acc;
        n_roff    = r_roff;
        n_fstart  = r_fstart;
        n_inptr   = r_inptr;
        w_trunc   = 1'b0;
        w_finish  = 1'b0;
        w_emit    = 1'b0;
        w_ptr     = 1'b0;
        w_value   = '0;
        w_kind    = dsoa_pkg::KIND_OWNER;
        w_estart  = r_fstart;
        w_nxt     = r_roff;
        w_next_ph = dsoa_pkg::PH_DONE;

        // restart: cut-off record reports before the new one begins
        if (r_in_start) begin
            if (r_phase != dsoa_pkg::PH_IDLE && r_phase != dsoa_pkg::PH_DONE) begin
                w_trunc = 1'b1;
            end
            n_roff   = '0;
            n_phase  = dsoa_pkg::PH_OWNER;
            n_bleft  = '0;
            n_lbl    = '0;
            n_nlen   = '0;
            n_acc    = '0;
            n_inptr  = 1'b0;
            n_fstart = '0;
        end

        if (n_phase != dsoa_pkg::PH_IDLE && n_phase != dsoa_pkg::PH_DONE) begin
            if (n_phase == dsoa_pkg::PH_OWNER || n_phase == dsoa_pkg::PH_NS ||
                n_phase == dsoa_pkg::PH_MAIL) begin
                if (n_nlen != 8'hFF) begin
                    n_nlen = n_nlen + 8'd1;
                end
                if (n_inptr) begin
                    w_finish = 1'b1;
                    w_ptr    = 1'b1;
                end else if (n_lbl != 8'd0) begin
                    n_lbl = n_lbl - 8'd1;
                end else if (r_in_byte == 8'd0) begin
                    w_finish = 1'b1;
                end else if (r_in_byte[7:6] == 2'b11) begin
                    n_inptr = 1'b1;
                end else begin
                    n_lbl = r_in_byte;
                end
                w_value = {24'd0, n_nlen};
            end else begin
                n_acc = {n_acc[23:0], r_in_byte};
                if (n_bleft != 3'd0) begin
                    n_bleft = n_bleft - 3'd1;
                end
                if (n_bleft == 3'd0) begin
                    w_finish = 1'b1;
                end
                w_value = n_acc;
            end

            w_nxt = (n_roff < OFFSET_CAP) ? n_roff + dsoa_pkg::OFFSET_W'(1) : n_roff;

            if (w_finish) begin
                w_emit    = (n_phase != dsoa_pkg::PH_RDLEN);
                w_kind    = dsoa_pkg::phase_kind(n_phase);
                w_estart  = n_fstart;
                w_next_ph = dsoa_pkg::phase_succ(n_phase);
                n_phase   = w_next_ph;
                n_bleft   = dsoa_pkg::phase_size(w_next_ph);
                n_lbl     = '0;
                n_nlen    = '0;
                n_acc     = '0;
                n_inptr   = 1'b0;
                n_fstart  = w_nxt;
            end
            n_roff = w_nxt;
        end
    end

    always_comb begin
        w_trunc_res.kind    = dsoa_pkg::KIND_TRUNC;
        w_trunc_res.value   = 32'(r_roff);
        w_trunc_res.offset  = r_fstart;
        w_trunc_res.via_ptr = 1'b0;
        w_trunc_res.last    = !w_emit;

        w_field_res.kind    = w_kind;
        w_field_res.value   = w_value;
        w_field_res.offset  = w_estart;
        w_field_res.via_ptr = w_ptr;
        w_field_res.last    = 1'b1;

        if (w_trunc) begin
            o_push.first  = w_trunc_res;
            o_push.second = w_field_res;
            o_push.count  = w_emit ? 2'd2 : 2'd1;
        end else begin
            o_push.first  = w_field_res;
            o_push.second = w_field_res;
            o_push.count  = w_emit ? 2'd1 : 2'd0;
        end
        if (!w_fire) begin
            o_push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= dsoa_pkg::PH_IDLE;
            r_bleft  <= '0;
            r_lbl    <= '0;
            r_nlen   <= '0;
            r_acc    <= '0;
            r_roff   <= '0;
            r_fstart <= '0;
            r_inptr  <= 1'b0;
        end else if (w_fire) begin
            r_phase  <= n_phase;
            r_bleft  <= n_bleft;
            r_lbl    <= n_lbl;
            r_nlen   <= n_nlen;
            r_acc    <= n_acc;
            r_roff   <= n_roff;
            r_fstart <= n_fstart;
            r_inptr  <= n_inptr;
        end
    end

endmodule

`default_nettype wire

[rtl/dsoa_rfifo.sv]
// ----------------------------------------------------------------------------
// dsoa_rfifo
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module dsoa_rfifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  dsoa_pkg::t_push      i_push,
    output logic                 o_room,
    dsoa_out_if.source           o_fld
);

    localparam int unsigned CW = dsoa_pkg::RQ_AW + 1;

    dsoa_pkg::t_result            r_mem [dsoa_pkg::RQ_DEPTH];
    logic [dsoa_pkg::RQ_AW-1:0]   r_wr;
    logic [dsoa_pkg::RQ_AW-1:0]   r_rd;
    logic [CW-1:0]                r_cnt;
    logic [CW-1:0]                n_cnt;
    logic                         w_pop;
    dsoa_pkg::t_result            w_head;

    // room for a full two-result push
    assign o_room = (r_cnt <= CW'(dsoa_pkg::RQ_DEPTH - 2));
    assign w_pop  = o_fld.valid && o_fld.ready;
    assign n_cnt  = r_cnt + CW'(i_push.count) - CW'(w_pop);

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + dsoa_pkg::RQ_AW'(1)] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + dsoa_pkg::RQ_AW'(i_push.count);
            r_rd  <= r_rd + dsoa_pkg::RQ_AW'(w_pop);
            r_cnt <= n_cnt;
        end
    end

    assign w_head                 = r_mem[r_rd];
    assign o_fld.valid            = (r_cnt != '0);
    assign o_fld.field_kind       = w_head.kind;
    assign o_fld.field_value      = w_head.value;
    assign o_fld.field_offset     = w_head.offset;
    assign o_fld.name_via_pointer = w_head.via_ptr;
    assign o_fld.result_last      = w_head.last;

endmodule

`default_nettype wire

[rtl/dns_soa_record_field_parser.sv]
// ----------------------------------------------------------------------------
// dns_soa_record_field_parser
// Byte-serial parser of a DNS SOA authority record into its fields.
// ----------------------------------------------------------------------------
// Usage:
//   i_rec carries one record byte per request, with record_start set on
//   the first byte of each record. o_fld carries one parsed field per
//   request: kind, value (integer or name length), start offset, a flag for
//   names closed by a compression pointer, and result_last on the final
//   result a byte causes. A byte causes zero, one or two results.
//   Data path: a byte taken from i_rec is held in the input register,
//   parsed by the combinational parse step and its results written to
//   the result queue, whose head drives o_fld. Throughput: one byte per
//   cycle while the queue has room for a double push; the output port hands
//   out one result a cycle; a truncation and a closed name go out in turn.
//   Reset: the parser goes idle, the result queue empties and i_rec.ready
//   is held low, so no byte is taken while reset is asserted.
//   Stall: when o_fld.ready is low results collect in a four-entry queue;
//   once fewer than two slots are free the parse step holds, the input
//   register fills and i_rec.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_soa_record_field_parser #(
    parameter int unsigned MAX_RECORD_BYTES = dsoa_pkg::MAX_RECORD_BYTES_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    dsoa_in_if.sink      i_rec,
    dsoa_out_if.source   o_fld
);

    // parse step to result queue
    dsoa_pkg::t_push w_push;
    // queue can take a double push
    logic            w_room;

    dsoa_core #(
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (i_rec),
        .i_room  (w_room),
        .o_push  (w_push)
    );

    dsoa_rfifo u_rfifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_fld   (o_fld)
    );

endmodule

`default_nettype wire
